FILE: hw/rtl/mpe_pkg.sv
// Shared types, constants and helpers of the matrix product engine.
package mpe_pkg;

  localparam int unsigned MaxDim     = 64;
  localparam int unsigned ElemWidth  = 16;
  localparam int unsigned DimWidth   = 7;
  localparam int unsigned AddrWidth  = $clog2(MaxDim * MaxDim);
  localparam int unsigned StoreDepth = MaxDim * MaxDim;
  localparam int unsigned LoadCntW   = $clog2(2 * MaxDim * MaxDim + 1);
  localparam int unsigned ReadCntW   = $clog2(MaxDim * MaxDim + 1);
  localparam int unsigned ColW       = $clog2(MaxDim);
  localparam int unsigned ProdWidth  = 2 * ElemWidth;
  localparam int unsigned AccWidth   = 38;

  // register indexes on the write port
  localparam logic [1:0] CfgRowsA    = 2'd0;
  localparam logic [1:0] CfgInnerDim = 2'd1;
  localparam logic [1:0] CfgColsB    = 2'd2;

  typedef enum logic {
    OpLoad = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotReady = 2'd1,
    StDone     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain
  } state_e;

  // control from the sequencer to the MAC unit
  typedef struct packed {
    logic clear;  // start of a new dot product
    logic valid;  // operand pair on the read ports
  } mac_ctrl_t;

  // zero reads as one, anything above MaxDim as MaxDim
  function automatic logic [DimWidth-1:0] dim_clamp(input logic [DimWidth-1:0] v);
    logic [DimWidth-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimWidth'(1);
    end else if (v > DimWidth'(MaxDim)) begin
      r = DimWidth'(MaxDim);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/matrix_product_engine.sv
// Matrix product engine top level: operand stores, read sequencer, output register.
// Load beat: stored at the accept edge. Read beat before the operands are
// complete or after all of C was returned: status beat valid the next cycle.
// Read beat with status ok: the element is formed on demand by the shared MAC unit,
// inner_dim issues through operand read, product and accumulator registers; no new
// beat is taken meanwhile; the single MAC and each store's one read port set this.
// Async active-low reset clears counters, flags and dims (all three to 1); stores
// need no clearing since no entry is read before it is written.
module matrix_product_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [mpe_pkg::DimWidth-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] element
  input  logic [0:0]                        s_axis_tuser,   // [0] op
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,   // [37:0] product_value
  output logic [1:0]                        m_axis_tuser,   // [1:0] status
  output logic                              m_axis_tlast    // last_element
);

  localparam int unsigned AW = mpe_pkg::AddrWidth;
  localparam int unsigned DW = mpe_pkg::DimWidth;
  localparam int unsigned LW = mpe_pkg::LoadCntW;
  localparam int unsigned RW = mpe_pkg::ReadCntW;
  localparam int unsigned CW = mpe_pkg::ColW;
  localparam int unsigned EW = mpe_pkg::ElemWidth;

  // ---------------------------------------------------------------------------
  // Dimension registers and derived sizes
  // ---------------------------------------------------------------------------
  logic [DW-1:0] rows_q, inner_q, cols_q;
  logic [DW-1:0] r_dim, k_dim, c_dim;
  logic [LW-1:0] size_a, size_b, total, size_c;
  logic          cfg_hit;

  assign r_dim  = mpe_pkg::dim_clamp(rows_q);
  assign k_dim  = mpe_pkg::dim_clamp(inner_q);
  assign c_dim  = mpe_pkg::dim_clamp(cols_q);
  assign size_a = LW'(r_dim) * LW'(k_dim);
  assign size_b = LW'(k_dim) * LW'(c_dim);
  assign size_c = LW'(r_dim) * LW'(c_dim);
  assign total  = size_a + size_b;

  // index 3 is decoded as nothing and does not restart the job
  assign cfg_hit = cfg_we_i && (cfg_idx_i == mpe_pkg::CfgRowsA ||
                                cfg_idx_i == mpe_pkg::CfgInnerDim ||
                                cfg_idx_i == mpe_pkg::CfgColsB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DW'(1);
      inner_q <= DW'(1);
      cols_q  <= DW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpe_pkg::CfgRowsA:    rows_q  <= cfg_data_i;
        mpe_pkg::CfgInnerDim: inner_q <= cfg_data_i;
        mpe_pkg::CfgColsB:    cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake decode
  // ---------------------------------------------------------------------------
  mpe_pkg::state_e state_q, state_d;
  logic s_fire, is_read, out_free;
  logic load_fire, read_fire, read_ok, finish, issue, mac_busy;

  logic [LW-1:0] load_cnt_q, load_cnt_d;
  logic [RW-1:0] read_cnt_q, read_cnt_d;
  logic          ready_q, ready_d;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign is_read   = (s_axis_tuser[0] == mpe_pkg::OpRead);
  assign load_fire = s_fire && !is_read;
  assign read_fire = s_fire && is_read;
  assign read_ok   = ready_q && (LW'(read_cnt_q) < size_c);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Operand stores: written by load beats, read by the MAC sequencer
  // ---------------------------------------------------------------------------
  logic [EW-1:0] mem_a [mpe_pkg::StoreDepth];
  logic [EW-1:0] mem_b [mpe_pkg::StoreDepth];
  logic          load_take, wr_a, wr_b;
  logic [AW-1:0] wr_addr_a, wr_addr_b;
  logic signed [EW-1:0] a_rd_q, b_rd_q;
  logic [AW-1:0] a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic          rd_v_q;

  assign load_take = load_fire && (load_cnt_q < total);
  assign wr_a      = load_take && (load_cnt_q < size_a);
  assign wr_b      = load_take && !(load_cnt_q < size_a);
  assign wr_addr_a = load_cnt_q[AW-1:0];
  assign wr_addr_b = AW'(load_cnt_q - size_a);

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr_a] <= s_axis_tdata;
    end
    if (wr_b) begin
      mem_b[wr_addr_b] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_rd_q <= mem_a[a_addr_q];
      b_rd_q <= mem_b[b_addr_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Job counters; a write to a dimension restarts the job
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] row_base_q, row_base_d;

  always_comb begin
    load_cnt_d = load_cnt_q;
    ready_d    = ready_q;
    read_cnt_d = read_cnt_q;
    col_d      = col_q;
    row_base_d = row_base_q;
    if (cfg_hit) begin
      load_cnt_d = '0;
      ready_d    = 1'b0;
      read_cnt_d = '0;
      col_d      = '0;
      row_base_d = '0;
    end else begin
      if (load_take) begin
        load_cnt_d = load_cnt_q + LW'(1);
        if (load_cnt_q + LW'(1) == total) begin
          ready_d = 1'b1;
        end
      end
      if (finish) begin
        read_cnt_d = read_cnt_q + RW'(1);
        // walk C row-major without dividing the linear index
        if (DW'(col_q) + DW'(1) == c_dim) begin
          col_d      = '0;
          row_base_d = row_base_q + AW'(k_dim);
        end else begin
          col_d      = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      ready_q    <= 1'b0;
      read_cnt_q <= '0;
      col_q      <= '0;
      row_base_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      ready_q    <= ready_d;
      read_cnt_q <= read_cnt_d;
      col_q      <= col_d;
      row_base_q <= row_base_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: one dot product of row i of A and column j of B per read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] step_q, step_d;
  logic          start, last_step;

  assign start     = read_fire && read_ok;
  assign last_step = (DW'(step_q) + DW'(1) == k_dim);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mpe_pkg::StIdle:  if (start) state_d = mpe_pkg::StMac;
      mpe_pkg::StMac:   if (last_step) state_d = mpe_pkg::StDrain;
      mpe_pkg::StDrain: if (!mac_busy && out_free) state_d = mpe_pkg::StIdle;
      default:          state_d = mpe_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    finish        = 1'b0;
    case (state_q)
      mpe_pkg::StIdle:  s_axis_tready = out_free;
      mpe_pkg::StMac:   issue = 1'b1;
      mpe_pkg::StDrain: finish = !mac_busy && out_free;
      default: ;
    endcase
  end

  // A walks along the row (+1), B down the column (+cols)
  always_comb begin
    a_addr_d = a_addr_q;
    b_addr_d = b_addr_q;
    step_d   = step_q;
    if (start) begin
      a_addr_d = row_base_q;
      b_addr_d = AW'(col_q);
      step_d   = '0;
    end else if (issue) begin
      a_addr_d = a_addr_q + AW'(1);
      b_addr_d = b_addr_q + AW'(c_dim);
      step_d   = step_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpe_pkg::StIdle;
      rd_v_q   <= 1'b0;
      step_q   <= '0;
      a_addr_q <= '0;
      b_addr_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= issue;
      step_q   <= step_d;
      a_addr_q <= a_addr_d;
      b_addr_q <= b_addr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared MAC
  // ---------------------------------------------------------------------------
  mpe_pkg::mac_ctrl_t            mac_ctrl;
  logic                          mac_pend;
  logic [mpe_pkg::AccWidth-1:0]  acc;

  assign mac_ctrl.clear = start;
  assign mac_ctrl.valid = rd_v_q;
  assign mac_busy       = rd_v_q || mac_pend;

  mpe_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .busy_o (mac_pend),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds one result beat, refilled as it is taken
  // ---------------------------------------------------------------------------
  logic                          out_v_q;
  logic [mpe_pkg::AccWidth-1:0]  out_data_q;
  mpe_pkg::status_e              out_st_q;
  logic                          out_last_q;
  logic                          status_beat;

  // early or late read: answered at once with a status beat
  assign status_beat = read_fire && !read_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (status_beat || finish) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= acc;
      out_st_q   <= mpe_pkg::StOk;
      out_last_q <= (LW'(read_cnt_q) + LW'(1) == size_c);
    end else if (status_beat) begin
      out_data_q <= '0;
      out_st_q   <= ready_q ? mpe_pkg::StDone : mpe_pkg::StNotReady;
      out_last_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_data_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (load_cnt_q == total))
    else $error("result flagged ready before all operands arrived");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(read_cnt_q) <= size_c)
    else $error("read counter ran past the result size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mpe_pkg::StIdle) |-> (ready_q && !s_axis_tready))
    else $error("sequencer busy without operands or still taking beats");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != mpe_pkg::StOk) |->
      (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("status beat carries data or last flag");

endmodule

FILE: hw/rtl/mpe_mac.sv
// Shared multiply-accumulate unit: registered product, then wide accumulate.
module mpe_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mpe_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [mpe_pkg::ElemWidth-1:0]  a_i,
  input  logic signed [mpe_pkg::ElemWidth-1:0]  b_i,
  output logic                                  busy_o,
  output logic        [mpe_pkg::AccWidth-1:0]   acc_o
);

  logic signed [mpe_pkg::ProdWidth-1:0] prod_q, prod_d;
  logic                                 prod_v_q;
  logic        [mpe_pkg::AccWidth-1:0]  acc_q, acc_d;

  assign prod_d = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + mpe_pkg::AccWidth'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.valid;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= prod_d;
    end
  end

  assign busy_o = prod_v_q;
  assign acc_o  = acc_q;

  // a new dot product never starts with a product still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |-> !prod_v_q)
    else $error("mac cleared while a product is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.valid |=> prod_v_q)
    else $error("operand pair lost in mac");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!prod_v_q && !ctrl_i.clear) |=> $stable(acc_q))
    else $error("accumulator moved without a product");

endmodule

FILE: tb/matrix_product_engine_tb.sv
// Self-checking testbench for the matrix product engine: load/read streams, cfg port.
module matrix_product_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget  = 500;  // beats that do real work
  localparam int unsigned QuietLimit  = 4000; // cycles with no handshake at all
  localparam int unsigned SettleCycles = 100; // longer than one read at the largest inner_dim
  localparam int unsigned HoldCycles  = 300;  // long receiver hold-off
  localparam int unsigned ReadCap     = 48;   // reads per job on big results

  // one input beat: op travels in tuser, element in tdata
  typedef struct {
    mpe_pkg::op_e op;
    logic [15:0]  element;
  } beat_t;

  // one result beat of C
  typedef struct {
    logic [mpe_pkg::AccWidth-1:0] value;
    mpe_pkg::status_e             st;
    logic                         last;
  } c_beat_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [1:0]                   cfg_idx_i     = mpe_pkg::CfgRowsA;
  logic [mpe_pkg::DimWidth-1:0] cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata  = '0;  // [15:0] element
  logic [0:0]                   s_axis_tuser  = '0;  // [0] op
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [39:0]                  m_axis_tdata;        // [37:0] product_value
  logic [1:0]                   m_axis_tuser;        // [1:0] status
  logic                         m_axis_tlast;        // last_element

  matrix_product_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  beat_t   beat_queue[$];      // beats waiting for the driver
  c_beat_t c_elements_due[$];  // result beats owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned cyc        = 0;
  int unsigned items_sent = 0;
  logic        calm;           // no random idling on either side in this window

  assign calm = (cyc >= 1500) && (cyc < 4500);

  // receiver hold-off handshake between the stimulus and the ready process
  int unsigned hold_req  = 0;
  int unsigned hold_ack  = 0;
  int unsigned hold_left = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h at cycle %0d", what, got, want, cyc);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of dims, operand stores and progress counters
  // ---------------------------------------------------------------------------
  logic [mpe_pkg::DimWidth-1:0] dim_raw [3] = '{7'd1, 7'd1, 7'd1};
  logic signed [15:0]  a_mem [mpe_pkg::StoreDepth];
  logic signed [15:0]  b_mem [mpe_pkg::StoreDepth];
  int unsigned         loaded   = 0;
  int unsigned         returned = 0;
  bit                  have_c   = 1'b0;

  // 0 acts as 1, anything over the max acts as the max
  function automatic int unsigned eff_dim(logic [mpe_pkg::DimWidth-1:0] v);
    if (v == '0) return 1;
    if (v > mpe_pkg::MaxDim) return mpe_pkg::MaxDim;
    return int'(v);
  endfunction

  // one element of C, row-major index idx; sum wraps at 64 bits, low 38 kept
  function automatic logic [mpe_pkg::AccWidth-1:0] product_element(int unsigned idx,
                                                                   int unsigned k,
                                                                   int unsigned c);
    longint      acc = 0;
    int unsigned i   = idx / c;
    int unsigned j   = idx % c;
    for (int unsigned t = 0; t < k; t++) begin
      acc += longint'(a_mem[i * k + t]) * longint'(b_mem[t * c + j]);
    end
    return acc[mpe_pkg::AccWidth-1:0];
  endfunction

  task automatic matrix_step(beat_t b);
    int unsigned r, k, c, size_a, total, size_c;
    c_beat_t     res;
    r      = eff_dim(dim_raw[0]);
    k      = eff_dim(dim_raw[1]);
    c      = eff_dim(dim_raw[2]);
    size_a = r * k;
    total  = size_a + k * c;
    size_c = r * c;
    if (b.op == mpe_pkg::OpLoad) begin
      // loads past the full operand count fall on the floor
      if (loaded < total) begin
        if (loaded < size_a) begin
          a_mem[loaded] = b.element;
        end else begin
          b_mem[loaded - size_a] = b.element;
        end
        loaded++;
        if (loaded == total) have_c = 1'b1;
      end
    end else begin
      res.value = '0;
      res.last  = 1'b0;
      if (!have_c) begin
        res.st = mpe_pkg::StNotReady;
      end else if (returned >= size_c) begin
        res.st = mpe_pkg::StDone;
      end else begin
        res.value = product_element(returned, k, c);
        res.st    = mpe_pkg::StOk;
        res.last  = (returned + 1 == size_c);
        returned++;
      end
      c_elements_due.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats, random gaps; predicts on every accepted beat.
  // Config writes are sampled here too, so the predictor sees one ordered history.
  // ---------------------------------------------------------------------------
  beat_t cur_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (cfg_we_i) begin
        // any valid register index restarts the job
        case (cfg_idx_i)
          mpe_pkg::CfgRowsA:    dim_raw[0] = cfg_data_i;
          mpe_pkg::CfgInnerDim: dim_raw[1] = cfg_data_i;
          mpe_pkg::CfgColsB:    dim_raw[2] = cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i inside {mpe_pkg::CfgRowsA, mpe_pkg::CfgInnerDim,
                              mpe_pkg::CfgColsB}) begin
          loaded   = 0;
          returned = 0;
          have_c   = 1'b0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) matrix_step(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beat_queue.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          cur_beat = beat_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_beat.element;
          s_axis_tuser  <= cur_beat.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result beat, drives tready with random stalls
  // and the occasional long hold-off.
  // ---------------------------------------------------------------------------
  c_beat_t head;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (c_elements_due.size() == 0) begin
          report_mismatch("result beat with nothing due", 64'(m_axis_tdata), '0);
        end else begin
          head = c_elements_due.pop_front();
          if (m_axis_tdata[mpe_pkg::AccWidth-1:0] !== head.value)
            report_mismatch("product_value", 64'(m_axis_tdata[mpe_pkg::AccWidth-1:0]),
                            64'(head.value));
          if (m_axis_tuser !== head.st)
            report_mismatch("status", 64'(m_axis_tuser), 64'(head.st));
          if (m_axis_tlast !== head.last)
            report_mismatch("last_element", 64'(m_axis_tlast), 64'(head.last));
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack      <= hold_req;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any handshake means the block hung
  // ---------------------------------------------------------------------------
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [mpe_pkg::DimWidth-1:0] stim_dim [3] = '{7'd1, 7'd1, 7'd1};
  logic [1:0]                   reg_index [3] = '{mpe_pkg::CfgRowsA, mpe_pkg::CfgInnerDim,
                                                  mpe_pkg::CfgColsB};

  task automatic send(mpe_pkg::op_e op, logic [15:0] v, bit counted = 1'b1);
    beat_t b;
    b.op      = op;
    b.element = v;
    beat_queue.push_back(b);
    if (counted) items_sent++;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // every queued beat taken and every owed result returned
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beat_queue.size() != 0 || s_axis_tvalid || c_elements_due.size() != 0);
  endtask

  // dims change only on an idle block; trailing loads get time to settle
  task automatic set_dims(logic [mpe_pkg::DimWidth-1:0] r, logic [mpe_pkg::DimWidth-1:0] k,
                          logic [mpe_pkg::DimWidth-1:0] c, logic [2:0] mask);
    logic [mpe_pkg::DimWidth-1:0] v [3];
    v = '{r, k, c};
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= reg_index[i];
        cfg_data_i  <= v[i];
        stim_dim[i] = v[i];
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic request_hold();
    @(posedge clk_i);
    hold_req <= hold_req + 1;
    @(negedge clk_i);
  endtask

  // one job: new dims, mostly a full load/read cycle, sometimes cut short
  task automatic run_random_job(bit with_hold, bit with_pause);
    logic [mpe_pkg::DimWidth-1:0] v [3];
    logic [2:0]          mask;
    int unsigned         r, k, c, total, size_c, n_loads, n_reads, big;
    bit                  broken;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(19))
        0:       v[i] = 7'd0;
        1, 2:    v[i] = 7'($urandom_range(5, 8));
        default: v[i] = 7'($urandom_range(1, 4));
      endcase
    end
    // now and then one dim at or above the max, the other two kept tiny
    if ($urandom_range(9) == 0) begin
      big = $urandom_range(2);
      for (int i = 0; i < 3; i++) v[i] = 7'($urandom_range(0, 2));
      v[big] = 7'($urandom_range(64, 127));
    end
    mask = ($urandom_range(4) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
    set_dims(v[0], v[1], v[2], mask);
    r      = eff_dim(stim_dim[0]);
    k      = eff_dim(stim_dim[1]);
    c      = eff_dim(stim_dim[2]);
    total  = r * k + k * c;
    size_c = r * c;
    repeat ($urandom_range(0, 2)) send(mpe_pkg::OpRead, rand_elem());
    // the hold-off and pause jobs always run to completion
    broken  = !with_hold && !with_pause && ($urandom_range(7) == 0);
    n_loads = broken ? $urandom_range(0, total - 1) : total;
    for (int unsigned n = 0; n < n_loads; n++) begin
      send(mpe_pkg::OpLoad, rand_elem());
      if ($urandom_range(19) == 0) send(mpe_pkg::OpRead, rand_elem());
    end
    if (broken) return;
    repeat ($urandom_range(0, 2)) send(mpe_pkg::OpLoad, rand_elem(), 1'b0);
    n_reads = (size_c > ReadCap) ? ReadCap : size_c;
    // reads pile up behind a stalled result port until the input backs up
    if (with_hold) begin
      wait_drained();
      request_hold();
    end
    for (int unsigned n = 0; n < n_reads; n++) begin
      // sender stops halfway until the block has caught up completely
      if (with_pause && n == n_reads / 2) wait_drained();
      send(mpe_pkg::OpRead, rand_elem());
    end
    // enough reads behind the held result to back up the input
    if (with_hold) repeat (3) send(mpe_pkg::OpRead, rand_elem());
    if (n_reads == size_c) repeat ($urandom_range(0, 2)) send(mpe_pkg::OpRead, rand_elem());
  endtask

  initial begin
    int unsigned job;
    job = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset dims 1x1x1: early reads, largest square, surplus load, reads past end
    send(mpe_pkg::OpRead, 16'h0000);
    send(mpe_pkg::OpLoad, 16'h8000);
    send(mpe_pkg::OpRead, 16'hFFFF);
    send(mpe_pkg::OpLoad, 16'h8000);
    send(mpe_pkg::OpLoad, 16'h7FFF, 1'b0);
    send(mpe_pkg::OpRead, 16'h0000);
    send(mpe_pkg::OpRead, 16'h5A5A);
    send(mpe_pkg::OpRead, 16'hA5A5);

    // zero and over-range registers: 1x64x1, all at the negative extreme -> +2^36
    set_dims(7'd0, 7'd127, 7'd0, 3'b111);
    repeat (128) send(mpe_pkg::OpLoad, 16'h8000);
    send(mpe_pkg::OpRead, 16'h0000);
    send(mpe_pkg::OpRead, 16'hFFFF);

    // 2x1x2 with mixed extreme signs
    set_dims(7'd2, 7'd1, 7'd2, 3'b111);
    send(mpe_pkg::OpLoad, 16'h7FFF);
    send(mpe_pkg::OpLoad, 16'h8000);
    send(mpe_pkg::OpLoad, 16'h8000);
    send(mpe_pkg::OpLoad, 16'h7FFF);
    repeat (5) send(mpe_pkg::OpRead, 16'h0000);

    // cols at exactly the max, A is -1
    set_dims(7'd1, 7'd1, 7'd64, 3'b111);
    send(mpe_pkg::OpLoad, 16'hFFFF);
    repeat (64) send(mpe_pkg::OpLoad, rand_elem());
    repeat (65) send(mpe_pkg::OpRead, 16'h0000);

    // a register write in the middle of loading restarts the job
    set_dims(7'd3, 7'd3, 7'd3, 3'b111);
    repeat (5) send(mpe_pkg::OpLoad, rand_elem());
    set_dims(7'd3, 7'd2, 7'd3, 3'b010);
    send(mpe_pkg::OpRead, 16'h0000);
    repeat (12) send(mpe_pkg::OpLoad, rand_elem());
    repeat (10) send(mpe_pkg::OpRead, 16'h0000);

    // random jobs; the third holds off the receiver, the fifth pauses the sender
    while (items_sent < ItemTarget || job < 5) begin
      job++;
      run_random_job(job == 3, job == 5);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
